>>> src/arb_pkg.sv
// Package with shared widths, types and saturation helpers for the affine box unit.
`default_nettype none

package arb_pkg;

  localparam int COORD_BITS   = 32;
  localparam int FRAC_BITS    = 16;
  localparam int PROD_BITS    = 2 * COORD_BITS;
  localparam int SHP_BITS     = PROD_BITS - FRAC_BITS;
  localparam int ACC_BITS     = SHP_BITS + 2;
  localparam int CFG_IDX_BITS = 3;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [SHP_BITS-1:0]   shprod_t;
  typedef logic signed [ACC_BITS-1:0]   acc_t;
  typedef logic [COORD_BITS-2:0]        extent_t;
  typedef coord_t [3:0]                 quad_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_M11  = 3'd0,
    REG_M12  = 3'd1,
    REG_M21  = 3'd2,
    REG_M22  = 3'd3,
    REG_OFFX = 3'd4,
    REG_OFFY = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    coord_t m11;
    coord_t m12;
    coord_t m21;
    coord_t m22;
    coord_t off_x;
    coord_t off_y;
  } coef_t;

  typedef struct packed {
    coord_t x0;
    coord_t y0;
    coord_t x1;
    coord_t y1;
  } corners_t;

  localparam coord_t COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam coord_t COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};
  localparam coord_t COEF_ONE  = coord_t'(64'd1 << FRAC_BITS);

  function automatic acc_t sext_coord(input coord_t v);
    return {{(ACC_BITS-COORD_BITS){v[COORD_BITS-1]}}, v};
  endfunction

  function automatic acc_t sext_shp(input shprod_t v);
    return {{(ACC_BITS-SHP_BITS){v[SHP_BITS-1]}}, v};
  endfunction

  // Clamps a wide sum into the signed coordinate range.
  function automatic coord_t sat_coord(input acc_t v);
    logic [ACC_BITS-COORD_BITS:0] top;
    top = v[ACC_BITS-1:COORD_BITS-1];
    if ((&top) || (~|top)) begin
      return v[COORD_BITS-1:0];
    end else if (v[ACC_BITS-1]) begin
      return COORD_MIN;
    end else begin
      return COORD_MAX;
    end
  endfunction

endpackage

`default_nettype wire

>>> src/affine_rect_bounds_unit.sv
// Top level of the affine rectangle bounding box unit with its matrix registers.
//
//   channel  | handshake               | payload
//   ---------+-------------------------+------------------------------------------
//   input    | in_valid_i / in_ready_o | rect_left_i, rect_top_i, rect_width_i,
//            |                         | rect_height_i
//   output   | out_valid_o/out_ready_i | box_left_o, box_top_o, box_width_o,
//            |                         | box_height_o
//   config   | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// One beat is accepted per clock unless a stall on the output has filled the pipeline.
// The five stages are corner sums, the eight 32x32 multipliers, the corner accumulation,
// the min/max search, and the extent clamp that also serves as the output register.
// Each stage carries its own valid bit and refills as soon as the one after it drains,
// so a stall on the output holds every beat in place. Reset empties the pipeline and
// loads the identity matrix; the config port is always ready.
`default_nettype none

module affine_rect_bounds_unit import arb_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CFG_IDX_BITS-1:0] cfg_index_i,
  input  coord_t                  cfg_data_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  coord_t                  rect_left_i,
  input  coord_t                  rect_top_i,
  input  coord_t                  rect_width_i,
  input  coord_t                  rect_height_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output coord_t                  box_left_o,
  output coord_t                  box_top_o,
  output extent_t                 box_width_o,
  output extent_t                 box_height_o
);

  coef_t    coef_q;
  logic     crn_valid, crn_ready;
  corners_t corners;
  logic     map_valid, map_ready;
  quad_t    cx, cy;
  logic signed [COORD_BITS:0] right_edge, bottom_edge;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q.m11   <= COEF_ONE;
      coef_q.m12   <= '0;
      coef_q.m21   <= '0;
      coef_q.m22   <= COEF_ONE;
      coef_q.off_x <= '0;
      coef_q.off_y <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_M11:  coef_q.m11   <= cfg_data_i;
        REG_M12:  coef_q.m12   <= cfg_data_i;
        REG_M21:  coef_q.m21   <= cfg_data_i;
        REG_M22:  coef_q.m22   <= cfg_data_i;
        REG_OFFX: coef_q.off_x <= cfg_data_i;
        REG_OFFY: coef_q.off_y <= cfg_data_i;
        default: ;
      endcase
    end
  end

  arb_corners u_corners (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .rect_left_i   (rect_left_i),
    .rect_top_i    (rect_top_i),
    .rect_width_i  (rect_width_i),
    .rect_height_i (rect_height_i),
    .out_valid_o   (crn_valid),
    .out_ready_i   (crn_ready),
    .corners_o     (corners)
  );

  arb_map u_map (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .coef_i      (coef_q),
    .in_valid_i  (crn_valid),
    .in_ready_o  (crn_ready),
    .corners_i   (corners),
    .out_valid_o (map_valid),
    .out_ready_i (map_ready),
    .cx_o        (cx),
    .cy_o        (cy)
  );

  arb_bounds u_bounds (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (map_valid),
    .in_ready_o   (map_ready),
    .cx_i         (cx),
    .cy_i         (cy),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .box_left_o   (box_left_o),
    .box_top_o    (box_top_o),
    .box_width_o  (box_width_o),
    .box_height_o (box_height_o)
  );

  // The far edge of the box stays inside the coordinate range, saturated or not.
  assign right_edge  = {box_left_o[COORD_BITS-1], box_left_o} + {2'b00, box_width_o};
  assign bottom_edge = {box_top_o[COORD_BITS-1], box_top_o} + {2'b00, box_height_o};

  a_backpressure_only_when_full : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i && crn_valid && map_valid)
  ) else $error("input stalled while the pipeline has room");

  a_right_edge_in_range : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (right_edge[COORD_BITS:COORD_BITS-1] != 2'b01)
  ) else $error("box left plus width leaves the coordinate range");

  a_bottom_edge_in_range : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (bottom_edge[COORD_BITS:COORD_BITS-1] != 2'b01)
  ) else $error("box top plus height leaves the coordinate range");

endmodule

`default_nettype wire

>>> src/arb_corners.sv
// First pipeline stage: forms the far corner coordinates of the rectangle.
`default_nettype none

module arb_corners import arb_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  coord_t   rect_left_i,
  input  coord_t   rect_top_i,
  input  coord_t   rect_width_i,
  input  coord_t   rect_height_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output corners_t corners_o
);

  logic     valid_q;
  corners_t corners_d, corners_q;

  assign in_ready_o = !valid_q || out_ready_i;

  always_comb begin
    corners_d.x0 = rect_left_i;
    corners_d.y0 = rect_top_i;
    corners_d.x1 = sat_coord(sext_coord(rect_left_i) + sext_coord(rect_width_i));
    corners_d.y1 = sat_coord(sext_coord(rect_top_i) + sext_coord(rect_height_i));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      corners_q <= corners_d;
    end
  end

  assign out_valid_o = valid_q;
  assign corners_o   = corners_q;

endmodule

`default_nettype wire

>>> src/arb_map.sv
// Multiply and accumulate stages that map the four corners through the matrix.
`default_nettype none

module arb_map import arb_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  coef_t    coef_i,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  corners_t corners_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output quad_t    cx_o,
  output quad_t    cy_o
);

  logic    mul_valid_q, acc_valid_q;
  logic    mul_ready, acc_ready;
  // Index 0 holds the term of the near corner coordinate, index 1 the far one.
  shprod_t xm11_d [2], xm11_q [2];
  shprod_t ym21_d [2], ym21_q [2];
  shprod_t xm12_d [2], xm12_q [2];
  shprod_t ym22_d [2], ym22_q [2];
  quad_t   cx_d, cx_q, cy_d, cy_q;

  assign acc_ready  = !acc_valid_q || out_ready_i;
  assign mul_ready  = !mul_valid_q || acc_ready;
  assign in_ready_o = mul_ready;

  // Full products shifted right arithmetically, which rounds toward minus infinity.
  function automatic shprod_t mul_shift(input coord_t a, input coord_t b);
    logic signed [PROD_BITS-1:0] p;
    p = PROD_BITS'(a) * PROD_BITS'(b);
    return p[PROD_BITS-1:FRAC_BITS];
  endfunction

  always_comb begin
    xm11_d[0] = mul_shift(corners_i.x0, coef_i.m11);
    xm11_d[1] = mul_shift(corners_i.x1, coef_i.m11);
    ym21_d[0] = mul_shift(corners_i.y0, coef_i.m21);
    ym21_d[1] = mul_shift(corners_i.y1, coef_i.m21);
    xm12_d[0] = mul_shift(corners_i.x0, coef_i.m12);
    xm12_d[1] = mul_shift(corners_i.x1, coef_i.m12);
    ym22_d[0] = mul_shift(corners_i.y0, coef_i.m22);
    ym22_d[1] = mul_shift(corners_i.y1, coef_i.m22);
  end

  // Corner c takes the far x when bit 0 is set and the far y when bit 1 is set.
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      cx_d[c] = sat_coord(sext_shp(xm11_q[c % 2]) + sext_shp(ym21_q[c / 2])
                          + sext_coord(coef_i.off_x));
      cy_d[c] = sat_coord(sext_shp(xm12_q[c % 2]) + sext_shp(ym22_q[c / 2])
                          + sext_coord(coef_i.off_y));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_valid_q <= 1'b0;
      acc_valid_q <= 1'b0;
    end else begin
      if (mul_ready) begin
        mul_valid_q <= in_valid_i;
      end
      if (acc_ready) begin
        acc_valid_q <= mul_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mul_ready && in_valid_i) begin
      xm11_q <= xm11_d;
      ym21_q <= ym21_d;
      xm12_q <= xm12_d;
      ym22_q <= ym22_d;
    end
    if (acc_ready && mul_valid_q) begin
      cx_q <= cx_d;
      cy_q <= cy_d;
    end
  end

  assign out_valid_o = acc_valid_q;
  assign cx_o        = cx_q;
  assign cy_o        = cy_q;

endmodule

`default_nettype wire

>>> src/arb_bounds.sv
// Minimum and maximum search over the mapped corners, then extent saturation.
`default_nettype none

module arb_bounds import arb_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  quad_t   cx_i,
  input  quad_t   cy_i,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output coord_t  box_left_o,
  output coord_t  box_top_o,
  output extent_t box_width_o,
  output extent_t box_height_o
);

  logic    mm_valid_q, ext_valid_q;
  logic    mm_ready, ext_ready;
  coord_t  lo_x_d, hi_x_d, lo_y_d, hi_y_d;
  coord_t  lo_x_q, hi_x_q, lo_y_q, hi_y_q;
  coord_t  left_q, top_q;
  extent_t width_d, height_d, width_q, height_q;
  logic signed [COORD_BITS:0] dw, dh;

  assign ext_ready  = !ext_valid_q || out_ready_i;
  assign mm_ready   = !mm_valid_q || ext_ready;
  assign in_ready_o = mm_ready;

  always_comb begin
    coord_t vx, vy;
    lo_x_d = $signed(cx_i[0]);
    hi_x_d = $signed(cx_i[0]);
    lo_y_d = $signed(cy_i[0]);
    hi_y_d = $signed(cy_i[0]);
    for (int c = 1; c < 4; c++) begin
      vx = $signed(cx_i[c]);
      vy = $signed(cy_i[c]);
      if (vx < lo_x_d) lo_x_d = vx;
      if (vx > hi_x_d) hi_x_d = vx;
      if (vy < lo_y_d) lo_y_d = vy;
      if (vy > hi_y_d) hi_y_d = vy;
    end
  end

  // The difference is never negative; only the upper clamp can act.
  always_comb begin
    dw = {hi_x_q[COORD_BITS-1], hi_x_q} - {lo_x_q[COORD_BITS-1], lo_x_q};
    dh = {hi_y_q[COORD_BITS-1], hi_y_q} - {lo_y_q[COORD_BITS-1], lo_y_q};
    width_d  = dw[COORD_BITS-1] ? COORD_MAX[COORD_BITS-2:0] : dw[COORD_BITS-2:0];
    height_d = dh[COORD_BITS-1] ? COORD_MAX[COORD_BITS-2:0] : dh[COORD_BITS-2:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mm_valid_q  <= 1'b0;
      ext_valid_q <= 1'b0;
    end else begin
      if (mm_ready) begin
        mm_valid_q <= in_valid_i;
      end
      if (ext_ready) begin
        ext_valid_q <= mm_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mm_ready && in_valid_i) begin
      lo_x_q <= lo_x_d;
      hi_x_q <= hi_x_d;
      lo_y_q <= lo_y_d;
      hi_y_q <= hi_y_d;
    end
    if (ext_ready && mm_valid_q) begin
      left_q   <= lo_x_q;
      top_q    <= lo_y_q;
      width_q  <= width_d;
      height_q <= height_d;
    end
  end

  assign out_valid_o  = ext_valid_q;
  assign box_left_o   = left_q;
  assign box_top_o    = top_q;
  assign box_width_o  = width_q;
  assign box_height_o = height_q;

endmodule

`default_nettype wire
